>>> rtl/core/lwbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lwbc_pkg;

  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd2;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic shift;
    logic mark;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_write_back_block_cache_core.sv
// Fully associative LRU block cache with write-back reporting.
// Input channel (in_valid/in_ready) carries a command, a block key and a
// data handle; the result channel (out_valid/out_ready) returns one
// transaction per command: hit, read handle and the write-back of a dirty
// evicted entry.
// Entries sit in a chain of cells ordered by recency, most recent in cell 0.
// A read hit or any put pushes the newer cells one step down the chain and writes
// the accessed entry at the head; when full, the last cell falls off.
// The accepting edge registers the key compare in every cell; the shift of the
// chain and the load of the result register follow once the output register
// is free. A new command is accepted only after that update has been done.
// A finished result waits in the output register while out_ready is low;
// the next command is accepted meanwhile, and its update holds until the
// output register frees up.
// Reset (synchronous, rst_n low) empties the cache and drops any pending
// transaction; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module lru_write_back_block_cache_core #(
  parameter int CAPACITY = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lwbc_pkg::CMD_W-1:0]        in_command,
  input  wire logic [lwbc_pkg::KEY_W-1:0]        in_block_key,
  input  wire logic [lwbc_pkg::HANDLE_W-1:0]     in_data_handle,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic [lwbc_pkg::HANDLE_W-1:0]          out_read_handle,
  output logic                                   out_writeback_valid,
  output logic [lwbc_pkg::KEY_W-1:0]             out_writeback_key,
  output logic [lwbc_pkg::HANDLE_W-1:0]          out_writeback_handle
);
  import lwbc_pkg::*;

  localparam int IDXW  = $clog2(CAPACITY);
  localparam int FILLW = $clog2(CAPACITY + 1);

  logic                busy_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [FILLW-1:0]    fill_r;

  logic                out_valid_r;
  logic                hit_r;
  logic [HANDLE_W-1:0] rd_r;
  logic                wbv_r;
  logic [KEY_W-1:0]    wbk_r;
  logic [HANDLE_W-1:0] wbh_r;

  logic                accept;
  logic                exec;
  logic                full;
  logic                any_hit;
  logic [IDXW-1:0]     hit_idx;
  entry_t              hit_ent;
  logic [IDXW-1:0]     pos;
  logic                put_miss;
  logic                evict_dirty;
  cell_ctrl_t          ctrl;
  entry_t              link [CAPACITY+1];
  logic [CAPACITY-1:0] match;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign exec     = busy_r && (!out_valid_r || out_ready);
  assign full     = (fill_r == FILLW'(CAPACITY));

  always_comb begin
    hit_idx = '0;
    hit_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDXW'(i);
        hit_ent = hit_ent | link[i+1];
      end
    end
  end

  assign any_hit     = |match;
  assign put_miss    = (cmd_r == CMD_PUT) && !any_hit;
  assign evict_dirty = put_miss && full && link[CAPACITY].valid && link[CAPACITY].dirty;
  assign pos         = any_hit ? hit_idx :
                       (full ? IDXW'(CAPACITY - 1) : fill_r[IDXW-1:0]);

  assign link[0].valid  = 1'b1;
  assign link[0].dirty  = put_miss ? 1'b0 : hit_ent.dirty;
  assign link[0].key    = key_r;
  assign link[0].handle = (cmd_r == CMD_PUT) ? handle_r : hit_ent.handle;

  assign ctrl.cmp   = accept;
  assign ctrl.shift = exec && (((cmd_r == CMD_READ) && any_hit) || (cmd_r == CMD_PUT));
  assign ctrl.mark  = exec && (cmd_r == CMD_MARK);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lwbc_cell #(
      .IDX  (g),
      .IDXW (IDXW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cmp_key (in_block_key),
      .pos     (pos),
      .link_in (link[g]),
      .entry_o (link[g+1]),
      .match_o (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec && put_miss && !full) begin
        fill_r <= fill_r + FILLW'(1);
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      key_r    <= in_block_key;
      handle_r <= in_data_handle;
    end
    if (exec) begin
      hit_r <= any_hit && (cmd_r == CMD_READ || cmd_r == CMD_PUT || cmd_r == CMD_MARK);
      rd_r  <= ((cmd_r == CMD_READ) && any_hit) ? hit_ent.handle : '0;
      wbv_r <= evict_dirty;
      wbk_r <= evict_dirty ? link[CAPACITY].key : '0;
      wbh_r <= evict_dirty ? link[CAPACITY].handle : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = hit_r;
  assign out_read_handle      = rd_r;
  assign out_writeback_valid  = wbv_r;
  assign out_writeback_key    = wbk_r;
  assign out_writeback_handle = wbh_r;

endmodule

`default_nettype wire

>>> rtl/core/lwbc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lwbc_cell #(
  parameter int IDX  = 0,
  parameter int IDXW = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lwbc_pkg::cell_ctrl_t              ctrl,
  input  wire logic [lwbc_pkg::KEY_W-1:0]        cmp_key,
  input  wire logic [IDXW-1:0]                   pos,
  input  wire lwbc_pkg::entry_t                  link_in,
  output lwbc_pkg::entry_t                       entry_o,
  output logic                                   match_o
);
  import lwbc_pkg::*;

  logic                valid_r;
  logic                dirty_r;
  logic [KEY_W-1:0]    key_r;
  logic [HANDLE_W-1:0] handle_r;
  logic                match_r;
  logic                take;

  assign take = ctrl.shift && (IDXW'(IDX) <= pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
      if (take) begin
        valid_r <= link_in.valid;
        dirty_r <= link_in.dirty;
      end else if (ctrl.mark && match_r) begin
        dirty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r    <= link_in.key;
      handle_r <= link_in.handle;
    end
  end

  assign entry_o.valid  = valid_r;
  assign entry_o.dirty  = dirty_r;
  assign entry_o.key    = key_r;
  assign entry_o.handle = handle_r;
  assign match_o        = match_r;

endmodule

`default_nettype wire

>>> verif/block_cache_checker.sv
`timescale 1ns / 1ps

module block_cache_checker #(
  parameter int CAPACITY = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [lwbc_pkg::CMD_W-1:0]      in_command,
  input  logic [lwbc_pkg::KEY_W-1:0]      in_block_key,
  input  logic [lwbc_pkg::HANDLE_W-1:0]   in_data_handle,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_hit,
  input  logic [lwbc_pkg::HANDLE_W-1:0]   out_read_handle,
  input  logic                            out_writeback_valid,
  input  logic [lwbc_pkg::KEY_W-1:0]      out_writeback_key,
  input  logic [lwbc_pkg::HANDLE_W-1:0]   out_writeback_handle,
  output int                              results_owed,
  output int                              fail_count
);
  import lwbc_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] read_handle;
    logic                wb_valid;
    logic [KEY_W-1:0]    wb_key;
    logic [HANDLE_W-1:0] wb_handle;
  } reply_t;

  logic                line_valid  [CAPACITY];
  logic                line_dirty  [CAPACITY];
  logic [KEY_W-1:0]    line_key    [CAPACITY];
  logic [HANDLE_W-1:0] line_handle [CAPACITY];
  int                  line_rank   [CAPACITY];
  int                  lines_used;
  int                  errors;
  reply_t              cache_replies [$];

  initial begin
    results_owed = 0;
    fail_count   = 0;
    errors       = 0;
  end

  // Move one line to the head of the recency order.
  function automatic void make_newest(int slot, int old_rank);
    for (int i = 0; i < CAPACITY; i++)
      if (i != slot && line_valid[i] && line_rank[i] < old_rank)
        line_rank[i] = line_rank[i] + 1;
    line_rank[slot] = 0;
  endfunction

  function automatic reply_t access_cache(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [HANDLE_W-1:0] handle);
    reply_t r;
    int     slot;
    int     victim;
    int     old_rank;
    r    = '0;
    slot = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (line_valid[i] && line_key[i] == key)
        slot = i;
    case (cmd)
      CMD_READ: begin
        if (slot >= 0) begin
          r.hit         = 1'b1;
          r.read_handle = line_handle[slot];
          make_newest(slot, line_rank[slot]);
        end
      end
      CMD_PUT: begin
        if (slot >= 0) begin
          r.hit             = 1'b1;
          line_handle[slot] = handle;
          make_newest(slot, line_rank[slot]);
        end else begin
          if (lines_used >= CAPACITY) begin
            victim = 0;
            for (int i = 1; i < CAPACITY; i++)
              if (line_rank[i] > line_rank[victim])
                victim = i;
            if (line_dirty[victim]) begin
              r.wb_valid  = 1'b1;
              r.wb_key    = line_key[victim];
              r.wb_handle = line_handle[victim];
            end
            slot     = victim;
            old_rank = line_rank[victim];
          end else begin
            slot = 0;
            for (int i = CAPACITY - 1; i >= 0; i--)
              if (!line_valid[i])
                slot = i;
            old_rank   = lines_used;
            lines_used = lines_used + 1;
          end
          line_valid[slot]  = 1'b1;
          line_key[slot]    = key;
          line_handle[slot] = handle;
          line_dirty[slot]  = 1'b0;
          make_newest(slot, old_rank);
        end
      end
      CMD_MARK: begin
        if (slot >= 0) begin
          r.hit            = 1'b1;
          line_dirty[slot] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_rank[i]  = 0;
      end
      lines_used = 0;
      cache_replies.delete();
    end else begin
      if (in_valid && in_ready)
        cache_replies.push_back(access_cache(in_command, in_block_key, in_data_handle));
      if (out_valid && out_ready) begin
        if (cache_replies.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual hit=%0b rd=%0h",
                   $time, out_hit, out_read_handle);
          errors++;
        end else begin
          want = cache_replies.pop_front();
          check_field("hit", want.hit, out_hit);
          check_field("read_handle", want.read_handle, out_read_handle);
          check_field("writeback_valid", want.wb_valid, out_writeback_valid);
          check_field("writeback_key", want.wb_key, out_writeback_key);
          check_field("writeback_handle", want.wb_handle, out_writeback_handle);
        end
      end
    end
    results_owed <= cache_replies.size();
    fail_count   <= errors;
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lwbc_pkg::*;

  localparam int               CAPACITY   = 32;
  localparam int               RANDOM_TXN = 400;
  localparam int               IDLE_LIMIT = 5000;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = '0;
  logic [KEY_W-1:0]    in_block_key = '0;
  logic [HANDLE_W-1:0] in_data_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic [HANDLE_W-1:0] out_read_handle;
  logic                out_writeback_valid;
  logic [KEY_W-1:0]    out_writeback_key;
  logic [HANDLE_W-1:0] out_writeback_handle;
  int                  results_owed;
  int                  fail_count;
  int                  idle_cycles = 0;
  int                  stall_cycle = 0;
  int                  stall_mode = 0;

  always #5 clk = ~clk;

  lru_write_back_block_cache_core #(.CAPACITY(CAPACITY)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_block_key        (in_block_key),
    .in_data_handle      (in_data_handle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_read_handle     (out_read_handle),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_key   (out_writeback_key),
    .out_writeback_handle(out_writeback_handle)
  );

  block_cache_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_block_key        (in_block_key),
    .in_data_handle      (in_data_handle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_read_handle     (out_read_handle),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_key   (out_writeback_key),
    .out_writeback_handle(out_writeback_handle),
    .results_owed        (results_owed),
    .fail_count          (fail_count)
  );

  // Receiver: periodically switch to one of four stall behaviors, picked at random.
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 50 == 0)
      stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = ($urandom_range(0, 9) < 7);
      2:       out_ready = ($urandom_range(0, 9) < 3);
      default: out_ready = (stall_cycle % 4 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [HANDLE_W-1:0] handle);
    @(negedge clk);
    in_valid       = 1'b1;
    in_command     = cmd;
    in_block_key   = key;
    in_data_handle = handle;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_cache;
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Mostly keys from a small pool at both ends of the key space, so that hits,
  // evictions and dirty write-backs happen often.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 9) == 0)
      return KEY_W'($urandom());
    k = KEY_W'($urandom_range(0, 47));
    return $urandom_range(0, 1) ? ~k : k;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_PUT;
    if (r < 70) return CMD_READ;
    if (r < 95) return CMD_MARK;
    return CMD_NONE;
  endfunction

  initial begin
    int sent;
    int burst;
    int gap;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_command(CMD_READ, 16'h0000, 32'h0);
    send_command(CMD_MARK, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_PUT,  16'h0000, 32'h0000_0000);
    send_command(CMD_PUT,  16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_READ, 16'hFFFF, 32'h0);
    send_command(CMD_READ, 16'h0000, 32'h1);
    send_command(CMD_MARK, 16'hFFFF, 32'h0);
    send_command(CMD_PUT,  16'hFFFF, 32'h1234_5678);
    send_command(CMD_READ, 16'hFFFF, 32'h0);
    send_command(CMD_PUT,  16'h5A5A, 32'hA5A5_A5A5);
    send_command(CMD_PUT,  16'hA5A5, 32'h5A5A_5A5A);
    send_command(CMD_READ, 16'h0000, 32'h0);
    send_command(CMD_NONE, 16'h0000, 32'h0);
    send_command(CMD_MARK, 16'h5A5A, 32'h0);
    send_command(CMD_READ, 16'h1234, 32'h0);
    drain_cache();

    sent = 0;
    while (sent < RANDOM_TXN) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_TXN; i++) begin
        send_command(pick_command(), pick_key(), HANDLE_W'($urandom()));
        sent++;
        if (sent == RANDOM_TXN / 2)
          drain_cache();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end

    drain_cache();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/core/lwbc_pkg.sv
rtl/core/lwbc_cell.sv
rtl/core/lru_write_back_block_cache_core.sv
verif/block_cache_checker.sv
verif/testbench.sv
